### hw/rtl/fqrb_pkg.sv
package fqrb_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned LEN_W    = 17;
  localparam int unsigned START_W  = 24;
  localparam int unsigned CAP_W    = 25;

  localparam int unsigned BATCH_DEPTH_DEFAULT = 16777216;
  localparam int unsigned MAX_READ_DEFAULT    = 65536;

  localparam logic [CAP_W-1:0] CAP_RESET = 25'h1000000;

  localparam logic [OFF_W-1:0] OFF_SAT = 16'hFFFF;
  localparam logic [LEN_W-1:0] LEN_SAT = 17'h10000;

  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_END   = 8'h45;

  localparam logic [KIND_W-1:0] KIND_NAME_BYTE = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NAME_END  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BASE      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ_IN   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ_OPEN = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ_LONG = 3'd5;
  localparam logic [KIND_W-1:0] KIND_DONE      = 3'd6;

  typedef enum logic [4:0] {
    PH_MARK = 5'b00001,
    PH_NAME = 5'b00010,
    PH_HDR  = 5'b00100,
    PH_SEQ  = 5'b01000,
    PH_SKIP = 5'b10000
  } phase_t;

  typedef struct packed {
    logic                has;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   value;
    logic [OFF_W-1:0]    read_offset;
    logic [LEN_W-1:0]    read_length;
    logic [START_W-1:0]  batch_start;
    logic [CAP_W-1:0]    batch_bytes;
    logic [CAP_W-1:0]    batch_reads;
  } res_t;

endpackage

### hw/rtl/fastq_record_batcher_core.sv
// FASTQ record batcher: takes FASTQ text one byte per item and returns at most one result
// per byte (name bytes, name end, bases with offset, read placement in the current batch,
// and a closing report on the byte marked as last). An item is taken every cycle while the
// result side keeps up; a result is registered, its byte passing through an input register,
// one pass of parse logic and a result register. Bytes of the header tail, the plus line and
// the quality line give no result. batch_capacity is written through its own port; the user
// must write it only while the block is idle, which the block itself does not enforce.
module fastq_record_batcher_core #(
  parameter int unsigned BATCH_DEPTH = fqrb_pkg::BATCH_DEPTH_DEFAULT,
  parameter int unsigned MAX_READ    = fqrb_pkg::MAX_READ_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fqrb_pkg::CAP_W-1:0]   batch_capacity,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [fqrb_pkg::BYTE_W-1:0]  text_byte,
  input  logic                         input_ends,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [fqrb_pkg::KIND_W-1:0]  kind,
  output logic [fqrb_pkg::BYTE_W-1:0]  value,
  output logic [fqrb_pkg::OFF_W-1:0]   read_offset,
  output logic [fqrb_pkg::LEN_W-1:0]   read_length,
  output logic [fqrb_pkg::START_W-1:0] batch_start,
  output logic [fqrb_pkg::CAP_W-1:0]   batch_bytes,
  output logic [fqrb_pkg::CAP_W-1:0]   batch_reads
);
  import fqrb_pkg::*;

  logic [CAP_W-1:0]  capacity;
  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_ends;
  logic              advance;
  res_t              res;

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= batch_capacity;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte <= text_byte;
      s1_ends <= input_ends;
    end
  end

  fqrb_parse #(
    .BATCH_DEPTH (BATCH_DEPTH),
    .MAX_READ    (MAX_READ)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .text_byte  (s1_byte),
    .input_ends (s1_ends),
    .capacity   (capacity),
    .res        (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.has;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      kind        <= res.kind;
      value       <= res.value;
      read_offset <= res.read_offset;
      read_length <= res.read_length;
      batch_start <= res.batch_start;
      batch_bytes <= res.batch_bytes;
      batch_reads <= res.batch_reads;
    end
  end

endmodule

### hw/rtl/fqrb_parse.sv
module fqrb_parse #(
  parameter int unsigned BATCH_DEPTH = fqrb_pkg::BATCH_DEPTH_DEFAULT,
  parameter int unsigned MAX_READ    = fqrb_pkg::MAX_READ_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [fqrb_pkg::BYTE_W-1:0] text_byte,
  input  logic                        input_ends,
  input  logic [fqrb_pkg::CAP_W-1:0]  capacity,
  output fqrb_pkg::res_t              res
);
  import fqrb_pkg::*;

  localparam int unsigned BW     = $clog2(MAX_READ + 1);
  localparam int unsigned SW     = BW + 2;
  localparam int unsigned WIDE_W = ((BW + 1 > CAP_W) ? BW + 1 : CAP_W) + 1;
  localparam bit          DEPTH_SMALL = (BATCH_DEPTH < (64'd1 << CAP_W));

  phase_t             phase, phase_next;
  logic [BW-1:0]      base_count, base_count_next;
  logic [SW-1:0]      skip_count, skip_count_next;
  logic [CAP_W-1:0]   used_bytes, used_bytes_next;
  logic [CAP_W-1:0]   read_total, read_total_next;

  logic [CAP_W-1:0]   eff_cap;
  logic [WIDE_W-1:0]  base_w, len_w, cap_w, fill_w;
  logic [SW-1:0]      skip_dec;
  logic               too_long, no_room;

  // effective capacity, clipped to the batch buffer depth
  assign eff_cap  = (DEPTH_SMALL && (capacity > CAP_W'(BATCH_DEPTH))) ?
                    CAP_W'(BATCH_DEPTH) : capacity;
  assign base_w   = WIDE_W'(base_count);
  assign len_w    = base_w + WIDE_W'(1);
  assign cap_w    = WIDE_W'(eff_cap);
  assign fill_w   = WIDE_W'(used_bytes) + len_w;
  assign too_long = (base_count >= BW'(MAX_READ)) || (len_w > cap_w);
  assign no_room  = fill_w > cap_w;
  assign skip_dec = (skip_count != '0) ? skip_count - SW'(1) : skip_count;

  always_comb begin
    phase_next      = phase;
    base_count_next = base_count;
    skip_count_next = skip_count;
    used_bytes_next = used_bytes;
    read_total_next = read_total;
    res             = '0;

    case (phase)
      PH_MARK: begin
        phase_next = PH_NAME;
      end
      PH_NAME: begin
        res.has = 1'b1;
        if (text_byte == CHAR_SPACE || text_byte == CHAR_NL) begin
          res.kind        = KIND_NAME_END;
          base_count_next = '0;
          phase_next      = (text_byte == CHAR_SPACE) ? PH_HDR : PH_SEQ;
        end else begin
          res.kind  = KIND_NAME_BYTE;
          res.value = text_byte;
        end
      end
      PH_HDR: begin
        if (text_byte == CHAR_NL) begin
          base_count_next = '0;
          phase_next      = PH_SEQ;
        end
      end
      PH_SEQ: begin
        res.has = 1'b1;
        if (text_byte == CHAR_NL) begin
          res.value       = CHAR_END;
          res.read_length = (len_w > WIDE_W'(LEN_SAT)) ? LEN_SAT : len_w[LEN_W-1:0];
          if (too_long) begin
            res.kind = KIND_READ_LONG;
          end else if (no_room) begin
            res.kind        = KIND_READ_OPEN;
            used_bytes_next = len_w[CAP_W-1:0];
            read_total_next = CAP_W'(1);
          end else begin
            res.kind        = KIND_READ_IN;
            res.batch_start = used_bytes[START_W-1:0];
            used_bytes_next = fill_w[CAP_W-1:0];
            read_total_next = read_total + CAP_W'(1);
          end
          skip_count_next = SW'(len_w + WIDE_W'(2));
          phase_next      = PH_SKIP;
        end else begin
          res.kind        = KIND_BASE;
          res.value       = text_byte;
          res.read_offset = (base_w > WIDE_W'(OFF_SAT)) ? OFF_SAT : base_w[OFF_W-1:0];
          if (base_count < BW'(MAX_READ)) begin
            base_count_next = base_count + BW'(1);
          end
        end
      end
      default: begin
        skip_count_next = skip_dec;
        if (skip_dec == '0) begin
          phase_next = PH_MARK;
        end
      end
    endcase

    res.batch_bytes = used_bytes_next;
    res.batch_reads = read_total_next;

    if (input_ends) begin
      res.has         = 1'b1;
      res.kind        = KIND_DONE;
      res.value       = '0;
      res.read_offset = '0;
      res.read_length = '0;
      res.batch_start = '0;
      phase_next      = PH_MARK;
      base_count_next = '0;
      skip_count_next = '0;
      used_bytes_next = '0;
      read_total_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_MARK;
      base_count <= '0;
      skip_count <= '0;
      used_bytes <= '0;
      read_total <= '0;
    end else if (step) begin
      phase      <= phase_next;
      base_count <= base_count_next;
      skip_count <= skip_count_next;
      used_bytes <= used_bytes_next;
      read_total <= read_total_next;
    end
  end

`ifndef SYNTHESIS
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    step && input_ends |=> phase == PH_MARK && used_bytes == '0 && read_total == '0)
    else $error("state not cleared after last item");

  a_reads_le_bytes: assert property (@(posedge clk) disable iff (rst)
    read_total <= used_bytes)
    else $error("more reads than bytes in batch");

  a_read_end_result: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_SEQ && text_byte == CHAR_NL && !input_ends |->
      res.has && (res.kind == KIND_READ_IN || res.kind == KIND_READ_OPEN ||
                  res.kind == KIND_READ_LONG))
    else $error("sequence newline gave no read result");

  a_skip_done: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_SKIP && skip_count == SW'(1) |=> phase == PH_MARK)
    else $error("quality skip did not finish");
`endif

endmodule

### test/tb_top.sv
module tb_top;
  import fqrb_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam int          STALL_CYCLES = 300;
  localparam int unsigned RANDOM_BYTES = 300;

  typedef struct packed {
    logic [BYTE_W-1:0] b;
    logic              last;
  } text_item_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CAP_W-1:0]    batch_capacity = CAP_RESET;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   text_byte = '0;
  logic                input_ends = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [BYTE_W-1:0]   value;
  logic [OFF_W-1:0]    read_offset;
  logic [LEN_W-1:0]    read_length;
  logic [START_W-1:0]  batch_start;
  logic [CAP_W-1:0]    batch_bytes;
  logic [CAP_W-1:0]    batch_reads;

  fastq_record_batcher_core dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .batch_capacity (batch_capacity),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .text_byte      (text_byte),
    .input_ends     (input_ends),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .value          (value),
    .read_offset    (read_offset),
    .read_length    (read_length),
    .batch_start    (batch_start),
    .batch_bytes    (batch_bytes),
    .batch_reads    (batch_reads)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_item_t  text_q[$];
  res_t        parse_results_q[$];
  bit          idle_on = 1'b1;
  logic        in_taken = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned bytes_taken = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned pushed = 0;
  int unsigned kind_seen[8];
  int          stall_left = 0;
  int          stalls_started = 0;
  int          stall_requests = 0;

  // parser shadow state
  phase_t           prs_phase = PH_MARK;
  logic [LEN_W-1:0] prs_bases = '0;
  logic [LEN_W-1:0] prs_skip = '0;
  logic [CAP_W-1:0] prs_used = '0;
  logic [CAP_W-1:0] prs_reads = '0;
  logic [CAP_W-1:0] prs_cap = CAP_RESET;

  function automatic res_t parse_text_byte(input logic [BYTE_W-1:0] b, input logic last);
    res_t             r;
    logic [17:0]      len;
    logic [CAP_W-1:0] cap_eff;
    r = '0;
    case (prs_phase)
      PH_MARK: prs_phase = PH_NAME;
      PH_NAME: begin
        r.has = 1'b1;
        if (b == CHAR_SPACE || b == CHAR_NL) begin
          r.kind = KIND_NAME_END;
          prs_bases = '0;
          prs_phase = (b == CHAR_SPACE) ? PH_HDR : PH_SEQ;
        end else begin
          r.kind = KIND_NAME_BYTE;
          r.value = b;
        end
      end
      PH_HDR: begin
        if (b == CHAR_NL) begin
          prs_bases = '0;
          prs_phase = PH_SEQ;
        end
      end
      PH_SEQ: begin
        r.has = 1'b1;
        if (b == CHAR_NL) begin
          len = prs_bases + 18'd1;
          cap_eff = (prs_cap > BATCH_DEPTH_DEFAULT) ? CAP_W'(BATCH_DEPTH_DEFAULT) : prs_cap;
          r.value = CHAR_END;
          r.read_length = (len > LEN_SAT) ? LEN_SAT : len[LEN_W-1:0];
          if (prs_bases >= MAX_READ_DEFAULT || len > cap_eff) begin
            r.kind = KIND_READ_LONG;
          end else if (prs_used + len > cap_eff) begin
            r.kind = KIND_READ_OPEN;
            prs_used = CAP_W'(len);
            prs_reads = CAP_W'(1);
          end else begin
            r.kind = KIND_READ_IN;
            r.batch_start = prs_used[START_W-1:0];
            prs_used = prs_used + CAP_W'(len);
            prs_reads = prs_reads + CAP_W'(1);
          end
          prs_skip = LEN_W'(len + 18'd2);
          prs_phase = PH_SKIP;
        end else begin
          r.kind = KIND_BASE;
          r.value = b;
          r.read_offset = (prs_bases > OFF_SAT) ? OFF_SAT : prs_bases[OFF_W-1:0];
          if (prs_bases < MAX_READ_DEFAULT) prs_bases = prs_bases + LEN_W'(1);
        end
      end
      default: begin
        if (prs_skip > 0) prs_skip = prs_skip - LEN_W'(1);
        if (prs_skip == 0) prs_phase = PH_MARK;
      end
    endcase
    r.batch_bytes = prs_used;
    r.batch_reads = prs_reads;
    if (last) begin
      r = '0;
      r.has = 1'b1;
      r.kind = KIND_DONE;
      r.batch_bytes = prs_used;
      r.batch_reads = prs_reads;
      prs_phase = PH_MARK;
      prs_bases = '0;
      prs_skip = '0;
      prs_used = '0;
      prs_reads = '0;
    end
    return r;
  endfunction

  function automatic void cmp_field(input string name, input logic [CAP_W-1:0] want,
                                    input logic [CAP_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // sampling, prediction, checking and the run limit
  always @(posedge clk) begin
    res_t want;
    res_t r;
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still awaited", cycle_count,
               parse_results_q.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      in_taken <= in_valid && in_ready;
      if (!rst) begin
        if (cfg_valid && cfg_ready) begin
          prs_cap = batch_capacity;
          cfg_writes++;
        end
        if (out_valid && out_ready) begin
          if (parse_results_q.size() == 0) begin
            $error("result with none awaited: kind %0d value %0d", kind, value);
            errors++;
          end else begin
            want = parse_results_q.pop_front();
            cmp_field("kind", CAP_W'(want.kind), CAP_W'(kind));
            cmp_field("value", CAP_W'(want.value), CAP_W'(value));
            cmp_field("read_offset", CAP_W'(want.read_offset), CAP_W'(read_offset));
            cmp_field("read_length", CAP_W'(want.read_length), CAP_W'(read_length));
            cmp_field("batch_start", CAP_W'(want.batch_start), CAP_W'(batch_start));
            cmp_field("batch_bytes", want.batch_bytes, batch_bytes);
            cmp_field("batch_reads", want.batch_reads, batch_reads);
            results_checked++;
            kind_seen[want.kind]++;
          end
        end
        if (in_valid && in_ready) begin
          r = parse_text_byte(text_byte, input_ends);
          if (r.has) parse_results_q.push_back(r);
          bytes_taken++;
        end
      end
    end
  end

  // byte sender
  always @(negedge clk) begin
    text_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (text_q.size() > 0 && !(idle_on && $urandom_range(99) < 14)) begin
        nxt = text_q.pop_front();
        text_byte <= nxt.b;
        input_ends <= nxt.last;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stalls_started < stall_requests) begin
      out_ready <= 1'b0;
      stalls_started <= stalls_started + 1;
      stall_left <= STALL_CYCLES;
    end else begin
      out_ready <= !(idle_on && $urandom_range(99) < 14);
    end
  end

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic last);
    text_item_t it;
    it.b = b;
    it.last = last;
    text_q.push_back(it);
    pushed++;
  endtask

  function automatic logic [BYTE_W-1:0] rand_byte();
    return BYTE_W'($urandom_range(255));
  endfunction

  function automatic logic [BYTE_W-1:0] pick_byte(input logic [BYTE_W-1:0] no_a,
                                                  input logic [BYTE_W-1:0] no_b);
    logic [BYTE_W-1:0] v;
    do v = rand_byte(); while (v == no_a || v == no_b);
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] base_byte();
    logic [BYTE_W-1:0] v;
    case ($urandom_range(6))
      0: v = "A";
      1: v = "C";
      2: v = "G";
      3: v = "T";
      4: v = "N";
      default: v = pick_byte(CHAR_NL, CHAR_NL);
    endcase
    return v;
  endfunction

  task automatic push_record(input int id_chars, input bit with_desc, input int seq_len,
                             input bit close_input);
    int skip_n;
    push_byte(rand_byte(), 1'b0);
    repeat (id_chars) push_byte(pick_byte(CHAR_SPACE, CHAR_NL), 1'b0);
    if (with_desc) begin
      push_byte(CHAR_SPACE, 1'b0);
      repeat ($urandom_range(6)) push_byte(pick_byte(CHAR_NL, CHAR_NL), 1'b0);
    end
    push_byte(CHAR_NL, 1'b0);
    repeat (seq_len) push_byte(base_byte(), 1'b0);
    push_byte(CHAR_NL, 1'b0);
    skip_n = seq_len + 3;
    for (int i = 0; i < skip_n; i++) push_byte(rand_byte(), close_input && i == skip_n - 1);
  endtask

  // a record cut short by the end of input
  task automatic push_partial();
    push_byte(rand_byte(), 1'b0);
    repeat ($urandom_range(3)) push_byte(pick_byte(CHAR_SPACE, CHAR_NL), 1'b0);
    push_byte(CHAR_NL, 1'b0);
    repeat ($urandom_range(5)) push_byte(base_byte(), 1'b0);
    push_byte(rand_byte(), 1'b1);
  endtask

  task automatic push_noise(input int n);
    repeat (n) push_byte(rand_byte(), $urandom_range(99) < 3);
  endtask

  // wait until every item is taken and every result is in, then let the pipe empty
  task automatic settle();
    while (text_q.size() > 0 || in_valid) @(negedge clk);
    while (parse_results_q.size() > 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    int unsigned seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_valid <= 1'b1;
    batch_capacity <= cap;
    do @(negedge clk); while (cfg_writes == seen);
    cfg_valid <= 1'b0;
  endtask

  function automatic int short_seq();
    return ($urandom_range(9) == 0) ? $urandom_range(40, 120) : $urandom_range(0, 24);
  endfunction

  initial begin
    int unsigned rnd_mark;
    int unsigned part_mark;
    int          pick;
    logic [CAP_W-1:0] cap;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // described header, extreme bytes, empty name and empty read, input closed on a marker
    push_byte("@", 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(CHAR_SPACE, 1'b0);
    push_byte(8'hF5, 1'b0);
    push_byte(CHAR_NL, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(CHAR_NL, 1'b0);
    repeat (5) push_byte(rand_byte(), 1'b0);
    push_byte("@", 1'b0);
    push_byte(CHAR_NL, 1'b0);
    push_byte(CHAR_NL, 1'b0);
    repeat (3) push_byte(rand_byte(), 1'b0);
    push_byte(8'h40, 1'b1);
    settle();

    // zero capacity: nothing fits
    set_capacity('0);
    repeat (6) push_record($urandom_range(0, 3), 1'($urandom_range(1)), $urandom_range(0, 3),
                           1'b0);
    push_byte(rand_byte(), 1'b1);
    settle();

    // one byte batches
    set_capacity(CAP_W'(1));
    repeat (8) push_record($urandom_range(0, 3), 1'($urandom_range(1)), $urandom_range(0, 2),
                           1'b0);
    push_byte(rand_byte(), 1'b1);
    settle();

    // small batches, state carried into the next setting
    set_capacity(CAP_W'($urandom_range(5, 40)));
    repeat (12) push_record($urandom_range(0, 6), 1'($urandom_range(1)), $urandom_range(0, 20),
                            1'b0);
    settle();

    // above depth, no idling, receiver holds off while bytes keep coming
    set_capacity('1);
    idle_on = 1'b0;
    stall_requests++;
    repeat (4) push_record($urandom_range(1, 8), 1'($urandom_range(1)), $urandom_range(20, 60),
                           1'b0);
    push_byte(rand_byte(), 1'b1);
    settle();
    idle_on = 1'b1;

    // default capacity restored
    set_capacity(CAP_RESET);
    push_record(4, 1'b1, 30, 1'b0);
    push_record(3, 1'b0, 10, 1'b1);
    settle();

    rnd_mark = pushed;
    while (pushed - rnd_mark < RANDOM_BYTES) begin
      case ($urandom_range(3))
        0: cap = CAP_W'($urandom_range(1, 64));
        1: cap = CAP_W'($urandom_range(65, 4000));
        2: cap = '1;
        default: cap = CAP_W'($urandom);
      endcase
      set_capacity(cap);
      idle_on = ($urandom_range(4) != 0);
      part_mark = pushed;
      while (pushed - part_mark < 100) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          push_record($urandom_range(0, 8), 1'($urandom_range(1)), short_seq(), 1'b0);
        end else if (pick < 93) begin
          push_noise($urandom_range(1, 8));
        end else begin
          push_partial();
        end
      end
      if ($urandom_range(1)) push_byte(rand_byte(), 1'b1);
      settle();
    end

    $display("checked %0d results from %0d text bytes over %0d capacity settings",
             results_checked, bytes_taken, cfg_writes);
    $display("reads placed %0d, batches opened %0d, reads too long %0d, inputs closed %0d",
             kind_seen[KIND_READ_IN], kind_seen[KIND_READ_OPEN], kind_seen[KIND_READ_LONG],
             kind_seen[KIND_DONE]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
